### rtl/core/mbss_pkg.sv
// Shared types and constants for the masked byte signature scan unit.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package mbss_pkg;

  // Default signature depth.
  localparam int MAX_PATTERN_BYTES_DEF = 128;

  // Fixed field widths of the input, result and configuration words.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PLEN_W   = 8;

  // Action codes of an input word.
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd2;

  // Status codes of a result word.
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ACK      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFFSET  = 2'd2;

  // Signature entry write command.
  typedef struct packed {
    logic               wr_en;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  sig_byte;
    logic               care;
  } load_cmd_t;

endpackage

`default_nettype wire

### rtl/core/mbss_window.sv
// Byte window shift line with an aligning shifter for the signature compare.
// Depends on mbss_pkg.
`default_nettype none

module mbss_window #(
  parameter int MAX_BYTES = mbss_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int SHW       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  shift_en,
  input  wire logic [mbss_pkg::BYTE_W-1:0]           data_byte,
  input  wire logic [SHW-1:0]                        shamt,
  output logic [MAX_BYTES-1:0][mbss_pkg::BYTE_W-1:0] aligned
);
  import mbss_pkg::*;

  // win[0] is the newest byte. Its contents before enough bytes arrive
  // are never used, so it needs no reset.
  logic [MAX_BYTES-1:0][BYTE_W-1:0] win;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] rev;
  logic [SHW:0][MAX_BYTES-1:0][BYTE_W-1:0] lvl;

  // Shift line: one byte in per scan word.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win[0] <= data_byte;
      for (int k = 1; k < MAX_BYTES; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  // Oldest byte first, so lane j lines up with signature position j after
  // a right shift by (MAX_BYTES - length).
  genvar gi, gl;
  generate
    for (gi = 0; gi < MAX_BYTES; gi++) begin : g_rev
      assign rev[gi] = win[MAX_BYTES-1-gi];
    end
  endgenerate

  assign lvl[0] = rev;

  // Logarithmic shifter, one stage per shift amount bit.
  generate
    for (gl = 0; gl < SHW; gl++) begin : g_lvl
      for (gi = 0; gi < MAX_BYTES; gi++) begin : g_lane
        if (gi + (1 << gl) < MAX_BYTES) begin : g_mv
          assign lvl[gl+1][gi] = shamt[gl] ? lvl[gl][gi + (1 << gl)] : lvl[gl][gi];
        end else begin : g_zf
          assign lvl[gl+1][gi] = shamt[gl] ? '0 : lvl[gl][gi];
        end
      end
    end
  endgenerate

  assign aligned = lvl[SHW];

endmodule

`default_nettype wire

### rtl/core/mbss_match.sv
// Signature and care flag storage with one compare lane per position.
// Depends on mbss_pkg.
`default_nettype none

module mbss_match #(
  parameter int MAX_BYTES = mbss_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int LW        = $clog2(MAX_BYTES + 1)
) (
  input  wire logic                                  clk,
  input  wire mbss_pkg::load_cmd_t                   load_cmd,
  input  wire logic [MAX_BYTES-1:0][mbss_pkg::BYTE_W-1:0] aligned,
  input  wire logic [LW-1:0]                         len,
  output logic                                       hit
);
  import mbss_pkg::*;

  // Store entries are written before use, so they carry no reset.
  logic [MAX_BYTES-1:0][BYTE_W-1:0] sig;
  logic [MAX_BYTES-1:0]             care;
  logic [MAX_BYTES-1:0]             lane_ok;

  genvar gj;
  generate
    for (gj = 0; gj < MAX_BYTES; gj++) begin : g_lane
      // Each entry decodes its own write; indexes beyond the depth hit none.
      always_ff @(posedge clk) begin
        if (load_cmd.wr_en && (32'(load_cmd.idx) == gj)) begin
          sig[gj]  <= load_cmd.sig_byte;
          care[gj] <= load_cmd.care;
        end
      end

      // A lane passes when it is past the length, a wildcard, or equal.
      assign lane_ok[gj] = (32'(len) <= gj) || !care[gj] || (sig[gj] == aligned[gj]);
    end
  endgenerate

  assign hit = &lane_ok;

endmodule

`default_nettype wire

### rtl/core/masked_byte_signature_scan_unit.sv
// Masked byte signature scan unit: top level with control and result word.
// A word accepted into stage one has its result word registered when stage one advances.
// Throughput: one word per cycle while not stalled; lanes and shifter are combinational.
// Reset (rst, synchronous): clears handshake state, byte count, search done flag and
// the configuration registers (length 1, base and offset 0); signature store is not cleared.
// Depends on mbss_pkg, mbss_window and mbss_match.
`default_nettype none

module masked_byte_signature_scan_unit #(
  parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mbss_pkg::ACTION_W-1:0]      action,
  input  wire logic [mbss_pkg::INDEX_W-1:0]       entry_index,
  input  wire logic [mbss_pkg::BYTE_W-1:0]        pattern_byte,
  input  wire logic                               care_flag,
  input  wire logic [mbss_pkg::BYTE_W-1:0]        data_byte,
  input  wire logic                               last_byte,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mbss_pkg::STATUS_W-1:0]           status,
  output logic [mbss_pkg::ADDR_W-1:0]             match_address,
  // Configuration write port
  input  wire logic                               cfg_write_en,
  input  wire logic [mbss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mbss_pkg::*;

  localparam int SHW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int LW  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [LW-1:0] MAX_L = LW'(MAX_PATTERN_BYTES);

  // Configuration registers and the registered base plus offset.
  logic [PLEN_W-1:0] pattern_length;
  logic [ADDR_W-1:0] base_address;
  logic [ADDR_W-1:0] result_offset;
  logic [ADDR_W-1:0] addr_bias;

  // Stage one holds the action of the word under evaluation.
  logic                s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic                s1_last;

  // Search state.
  logic [ADDR_W-1:0] bytes_seen;
  logic              match_done;

  logic              accept;
  logic              adv;
  logic [LW-1:0]     len;
  logic [SHW-1:0]    shamt;
  logic              hit;
  logic              found;
  load_cmd_t         load_cmd;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] aligned;

  logic [STATUS_W-1:0] status_next;
  logic [ADDR_W-1:0]   addr_next;
  logic                match_done_next;

  // Handshake: the stage advances when the result register is free or drains.
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PLEN_W'(1);
      base_address   <= '0;
      result_offset  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_wdata[PLEN_W-1:0];
        CFG_BASE_ADDRESS:   base_address   <= cfg_wdata[ADDR_W-1:0];
        CFG_RESULT_OFFSET:  result_offset  <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Registered base plus offset: the user must not read it right after a write; not enforced.
  always_ff @(posedge clk) begin
    addr_bias <= base_address + result_offset;
  end

  // Active length clamped to one through the store depth.
  always_comb begin
    if (pattern_length == '0) begin
      len = LW'(1);
    end else if (32'(pattern_length) > MAX_PATTERN_BYTES) begin
      len = MAX_L;
    end else begin
      len = LW'(pattern_length);
    end
  end

  assign shamt = SHW'(MAX_L - len);

  // Store writes happen when a load word is accepted.
  always_comb begin
    load_cmd.wr_en    = accept && (action == ACT_LOAD);
    load_cmd.idx      = entry_index;
    load_cmd.sig_byte = pattern_byte;
    load_cmd.care     = care_flag;
  end

  mbss_window #(
    .MAX_BYTES (MAX_PATTERN_BYTES),
    .SHW       (SHW)
  ) u_window (
    .clk       (clk),
    .shift_en  (accept && (action == ACT_SCAN)),
    .data_byte (data_byte),
    .shamt     (shamt),
    .aligned   (aligned)
  );

  mbss_match #(
    .MAX_BYTES (MAX_PATTERN_BYTES),
    .LW        (LW)
  ) u_match (
    .clk      (clk),
    .load_cmd (load_cmd),
    .aligned  (aligned),
    .len      (len),
    .hit      (hit)
  );

  // Stage one fills on accept and empties on advance; the saturating byte count
  // updates on accept. Bytes that arrive after a report still shift in; a start discards them.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      bytes_seen <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (accept && (action == ACT_START)) begin
        bytes_seen <= '0;
      end else if (accept && (action == ACT_SCAN) && (bytes_seen != '1)) begin
        bytes_seen <= bytes_seen + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_last   <= last_byte;
    end
  end

  // Evaluation of the word in stage one against the state it left behind.
  assign found = hit && (bytes_seen >= ADDR_W'(len));

  always_comb begin
    status_next     = ST_NONE;
    addr_next       = '0;
    match_done_next = match_done;
    case (s1_action)
      ACT_LOAD: begin
        status_next = ST_ACK;
      end
      ACT_START: begin
        status_next     = ST_ACK;
        match_done_next = 1'b0;
      end
      ACT_SCAN: begin
        if (!match_done) begin
          if (found) begin
            status_next     = ST_MATCH;
            addr_next       = addr_bias + bytes_seen - ADDR_W'(len);
            match_done_next = 1'b1;
          end else if (s1_last) begin
            status_next     = ST_NOTFOUND;
            match_done_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register and search done flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      match_done <= 1'b0;
    end else begin
      if (adv) begin
        out_valid  <= 1'b1;
        match_done <= match_done_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status        <= status_next;
      match_address <= addr_next;
    end
  end

`ifndef ASSERT_OFF
  // The input side is only held off while a word waits in stage one.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with stage one empty");

  // Only a match word carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_MATCH)) |-> (match_address == '0))
    else $error("address set on a non-match word");

  // After a report, scanned bytes produce nothing until a start.
  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    (adv && match_done && (s1_action == ACT_SCAN)) |=> (status == ST_NONE))
    else $error("report after search completed");

  // A start clears the done flag.
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_action == ACT_START)) |=> !match_done)
    else $error("done flag survived a start");

  // A report sets the done flag.
  a_report_sets_done: assert property (@(posedge clk) disable iff (rst)
    (adv && ((status_next == ST_MATCH) || (status_next == ST_NOTFOUND))) |=> match_done)
    else $error("report without done flag");
`endif

endmodule

`default_nettype wire
